>>> sv/nonrestoring_unsigned_divider_defines.svh
// assertion macros for the divider
`ifndef NONRESTORING_UNSIGNED_DIVIDER_DEFINES_SVH
`define NONRESTORING_UNSIGNED_DIVIDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define NRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/nrd_pkg.sv
// shared types and constants of the non-restoring divider
package nrd_pkg;

	localparam int unsigned DEF_WIDTH = 32;
	localparam int unsigned FIELD_W   = 32;

	typedef struct packed {
		logic [FIELD_W-1:0] dividend;
		logic [FIELD_W-1:0] divisor;
	} in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] quotient;
		logic [FIELD_W-1:0] remainder;
		logic               divide_by_zero;
	} out_t;

endpackage

>>> sv/nrd_cell.sv
// one add/subtract step of the divider array, with its own stage register
module nrd_cell #(
	parameter int unsigned WIDTH = nrd_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH:0]   in_a,
	input  logic [WIDTH-1:0] in_q,
	input  logic [WIDTH-1:0] in_m,
	input  logic             in_dz,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH:0]   out_a,
	output logic [WIDTH-1:0] out_q,
	output logic [WIDTH-1:0] out_m,
	output logic             out_dz
);

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] q_next;
	logic             valid_q;
	logic [WIDTH:0]   a_q;
	logic [WIDTH-1:0] q_q;
	logic [WIDTH-1:0] m_q;
	logic             dz_q;

	// top quotient bit moves into the partial remainder
	assign shifted = {in_a[WIDTH-1:0], in_q[WIDTH-1]};

	// sign of the old partial remainder picks add or subtract
	always_comb begin
		if (in_a[WIDTH]) begin
			sum = shifted + {1'b0, in_m};
		end else begin
			sum = shifted - {1'b0, in_m};
		end
		q_next = {in_q[WIDTH-2:0], ~sum[WIDTH]};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_q  <= sum;
			q_q  <= q_next;
			m_q  <= in_m;
			dz_q <= in_dz;
		end
	end

	assign out_valid = valid_q;
	assign out_a     = a_q;
	assign out_q     = q_q;
	assign out_m     = m_q;
	assign out_dz    = dz_q;

endmodule

>>> sv/nrd_fix.sv
// final remainder correction and output register
module nrd_fix #(
	parameter int unsigned WIDTH = nrd_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH:0]   in_a,
	input  logic [WIDTH-1:0] in_q,
	input  logic [WIDTH-1:0] in_m,
	input  logic             in_dz,
	output logic             out_valid,
	input  logic             out_ready,
	output nrd_pkg::out_t    out_data
);

	logic [WIDTH:0]  fixed;
	nrd_pkg::out_t   res;
	logic            valid_q;
	nrd_pkg::out_t   data_q;

	// a zero divisor leaves the dividend in the remainder and all ones in the quotient
	always_comb begin
		if (in_a[WIDTH]) begin
			fixed = in_a + {1'b0, in_m};
		end else begin
			fixed = in_a;
		end
		res.quotient       = nrd_pkg::FIELD_W'(in_q);
		res.remainder      = nrd_pkg::FIELD_W'(fixed[WIDTH-1:0]);
		res.divide_by_zero = in_dz;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> sv/nonrestoring_unsigned_divider.sv
// one add/subtract cell per quotient bit plus an output stage, each with its own register
// throughput: one word per cycle while out_ready does not stall the output stage
// each stage holds one word and moves on when the next stage is empty or moving
// reset: arst_n clears every stage valid bit at once; data registers are not reset
// after reset in_ready is high, since every stage is empty
`include "nonrestoring_unsigned_divider_defines.svh"

module nonrestoring_unsigned_divider #(
	parameter int unsigned WIDTH = nrd_pkg::DEF_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  nrd_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output nrd_pkg::out_t out_data
);

	logic             v   [WIDTH+1];
	logic             rdy [WIDTH+1];
	logic [WIDTH:0]   a   [WIDTH+1];
	logic [WIDTH-1:0] q   [WIDTH+1];
	logic [WIDTH-1:0] m   [WIDTH+1];
	logic             dz  [WIDTH+1];
	logic [WIDTH:0]   a_fixed;
	logic [WIDTH:0]   a_last;
	logic [WIDTH-1:0] m_last;
	logic             last_pos;
	logic             last_neg;
	logic             dz_move;
	logic             dz_out;

	// chain head: empty partial remainder, dividend in the quotient register
	assign v[0]    = in_valid;
	assign in_ready = rdy[0];
	assign a[0]    = '0;
	assign q[0]    = WIDTH'(in_data.dividend);
	assign m[0]    = WIDTH'(in_data.divisor);
	assign dz[0]   = (WIDTH'(in_data.divisor) == '0);

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		nrd_cell #(.WIDTH(WIDTH)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v[i]),
			.in_ready (rdy[i]),
			.in_a     (a[i]),
			.in_q     (q[i]),
			.in_m     (m[i]),
			.in_dz    (dz[i]),
			.out_valid(v[i+1]),
			.out_ready(rdy[i+1]),
			.out_a    (a[i+1]),
			.out_q    (q[i+1]),
			.out_m    (m[i+1]),
			.out_dz   (dz[i+1])
		);
	end

	nrd_fix #(.WIDTH(WIDTH)) u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v[WIDTH]),
		.in_ready (rdy[WIDTH]),
		.in_a     (a[WIDTH]),
		.in_q     (q[WIDTH]),
		.in_m     (m[WIDTH]),
		.in_dz    (dz[WIDTH]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign a_last   = a[WIDTH];
	assign m_last   = m[WIDTH];
	assign a_fixed  = a_last + {1'b0, m_last};
	assign last_pos = v[WIDTH] && !dz[WIDTH] && !a_last[WIDTH];
	assign last_neg = v[WIDTH] && !dz[WIDTH] && a_last[WIDTH];
	assign dz_move  = v[WIDTH] && rdy[WIDTH] && dz[WIDTH];
	assign dz_out   = out_valid && out_data.divide_by_zero
		&& (out_data.quotient == nrd_pkg::FIELD_W'({WIDTH{1'b1}}));

	// after the last step the partial remainder lies in [-divisor, divisor)
	`NRD_ASSERT_IMP(a_pos_range, last_pos, a_last[WIDTH-1:0] < m_last, "remainder not below divisor")
	`NRD_ASSERT_IMP(a_neg_range, last_neg, !a_fixed[WIDTH], "remainder below minus divisor")
	`NRD_ASSERT_NXT(a_dz_ones, dz_move, dz_out, "zero divisor word without all-ones quotient")

endmodule

>>> bench/nonrestoring_unsigned_divider_test.sv
// testbench for the pipelined non-restoring unsigned divider
`timescale 1ns / 1ps

module nonrestoring_unsigned_divider_test;

	localparam int unsigned WIDTH       = nrd_pkg::DEF_WIDTH;
	localparam int unsigned IDLE_LIMIT  = 3000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_REPORTS = 10;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          out_ready = 1'b0;
	nrd_pkg::in_t  in_data   = '0;
	logic          in_ready;
	logic          out_valid;
	nrd_pkg::out_t out_data;

	nrd_pkg::out_t pending_results[$];
	int unsigned   mismatch_count = 0;
	int unsigned   send_idle_pct  = 0;
	int unsigned   stall_pct      = 0;
	bit            hold_pending   = 1'b0;
	int unsigned   idle_cycles    = 0;

	nonrestoring_unsigned_divider #(
		.WIDTH(WIDTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shift-and-add/subtract over a WIDTH+1 bit partial remainder, sign in the top bit
	function automatic nrd_pkg::out_t divide_nonrestoring(input nrd_pkg::in_t w);
		logic [WIDTH:0]   part;
		logic [WIDTH-1:0] quo;
		logic [WIDTH-1:0] dsr;
		nrd_pkg::out_t    r;
		int               i;
		dsr  = w.divisor[WIDTH-1:0];
		quo  = w.dividend[WIDTH-1:0];
		part = '0;
		r    = '0;
		if (dsr == '0) begin
			r.quotient       = nrd_pkg::FIELD_W'({WIDTH{1'b1}});
			r.remainder      = nrd_pkg::FIELD_W'(quo);
			r.divide_by_zero = 1'b1;
			return r;
		end
		for (i = 0; i < WIDTH; i++) begin
			if (part[WIDTH])
				part = {part[WIDTH-1:0], quo[WIDTH-1]} + {1'b0, dsr};
			else
				part = {part[WIDTH-1:0], quo[WIDTH-1]} - {1'b0, dsr};
			quo = {quo[WIDTH-2:0], ~part[WIDTH]};
		end
		// negative remainder gets the divisor added back once
		if (part[WIDTH])
			part = part + {1'b0, dsr};
		r.quotient  = nrd_pkg::FIELD_W'(quo);
		r.remainder = nrd_pkg::FIELD_W'(part[WIDTH-1:0]);
		return r;
	endfunction

	// operand mix weighted towards the awkward corners of the array
	function automatic nrd_pkg::in_t rand_operands();
		nrd_pkg::in_t w;
		w.dividend = $urandom();
		w.divisor  = $urandom();
		case ($urandom_range(15))
			0: w.divisor = '0;
			1, 2: w.divisor = $urandom_range(1, 15);
			3: w.divisor = 32'h1 << $urandom_range(31);
			4: w.divisor = $urandom() | 32'h8000_0000;
			5: w.divisor = w.dividend - $urandom_range(0, 3) + $urandom_range(0, 3);
			6: w.dividend = $urandom_range(0, 255);
			7: w.divisor = $urandom() >> $urandom_range(31);
			8: w.dividend = $urandom() >> $urandom_range(31);
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_word(input nrd_pkg::in_t w);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(divide_nonrestoring(w));
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	task automatic test_corner_operands();
		set_idling(0, 0);
		send_word({32'h0000_0000, 32'h0000_0001});
		send_word({32'hFFFF_FFFF, 32'h0000_0001});
		send_word({32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_word({32'h0000_0000, 32'hFFFF_FFFF});
		send_word({32'h0000_0001, 32'hFFFF_FFFF});
		send_word({32'hFFFF_FFFE, 32'hFFFF_FFFF});
		send_word({32'hFFFF_FFFF, 32'hFFFF_FFFE});
		send_word({32'h8000_0000, 32'h0000_0001});
		send_word({32'h8000_0000, 32'h8000_0000});
		send_word({32'h7FFF_FFFF, 32'h8000_0000});
		send_word({32'hFFFF_FFFF, 32'h8000_0000});
		send_word({32'h8000_0000, 32'hFFFF_FFFF});
		send_word({32'hFFFF_FFFF, 32'h0000_0002});
		send_word({32'h0000_0007, 32'h0000_0002});
		send_word({32'h0000_0064, 32'h0000_0007});
		send_word({32'h0000_0001, 32'h0000_0001});
		send_word({32'h1234_5678, 32'h0000_0010});
		send_word({32'h5555_5555, 32'hAAAA_AAAA});
		send_word({32'hAAAA_AAAA, 32'h5555_5555});
	endtask

	task automatic test_divide_by_zero();
		set_idling(0, 0);
		send_word({32'h0000_0000, 32'h0000_0000});
		send_word({32'hFFFF_FFFF, 32'h0000_0000});
		send_word({32'h0000_0005, 32'h0000_0000});
		send_word({32'h8000_0001, 32'h0000_0000});
	endtask

	task automatic test_random_back_to_back();
		set_idling(0, 0);
		repeat (300) send_word(rand_operands());
	endtask

	task automatic test_random_sparse_input();
		set_idling(65, 0);
		repeat (280) send_word(rand_operands());
	endtask

	task automatic test_random_output_stall();
		set_idling(0, 65);
		repeat (280) send_word(rand_operands());
	endtask

	task automatic test_random_light_idling();
		set_idling(6, 6);
		repeat (200) send_word(rand_operands());
	endtask

	// receiver holds off long enough for every stage to fill and in_ready to drop
	task automatic test_input_backpressure();
		set_idling(0, 0);
		hold_pending = 1'b1;
		repeat (90) send_word(rand_operands());
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// catch any stray word after the last expected one
		repeat (WIDTH + 10) @(posedge clk);
	endtask

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_result
		nrd_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result word: q=%h r=%h dbz=%b",
						out_data.quotient, out_data.remainder, out_data.divide_by_zero);
			end else begin
				want = pending_results.pop_front();
				if (out_data.quotient !== want.quotient
						|| out_data.remainder !== want.remainder
						|| out_data.divide_by_zero !== want.divide_by_zero) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result mismatch: expected q=%h r=%h dbz=%b, got q=%h r=%h dbz=%b",
							want.quotient, want.remainder, want.divide_by_zero,
							out_data.quotient, out_data.remainder, out_data.divide_by_zero);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_corner_operands();
		test_divide_by_zero();
		test_random_back_to_back();
		test_random_sparse_input();
		test_random_output_stall();
		test_random_light_idling();
		test_input_backpressure();
		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
